// ===== sv/dlv_pkg.sv =====
// shared types, constants and cordic helpers for the lag-one doppler velocity estimator
package dlv_pkg;

  localparam int MAX_POINTS      = 256;
  localparam int POINT_W         = $clog2(MAX_POINTS);
  localparam int DEP_W           = POINT_W + 1;
  localparam int MAX_ENSEMBLE    = 64;
  localparam int ROW_W           = $clog2(MAX_ENSEMBLE);
  localparam int ENS_W           = ROW_W + 1;
  localparam int SAMPLE_W        = 16;
  localparam int PROD_SW         = 2 * SAMPLE_W;
  localparam int LAG_W           = PROD_SW + 1;
  localparam int ACC_W           = 40;
  localparam int CORDIC_W        = ACC_W + 4;
  localparam int ANGLE_W         = 34;
  localparam int CORDIC_STEPS    = 16;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int MAG_W           = 32;
  localparam int SCALE_W         = 24;
  localparam int PROD_W          = MAG_W + SCALE_W;
  localparam int SCALE_SHIFT     = 47;
  localparam int CODE_W          = PROD_W - SCALE_SHIFT;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 9;

  localparam logic [SCALE_W-1:0]        SCALE_Q16   = 24'd8327302;
  localparam logic [CODE_W-1:0]         CODE_MAX    = 9'd127;
  localparam logic signed [ANGLE_W-1:0] HALF_PI     = 34'sd1073741824;
  localparam logic [ENS_W-1:0]          ENS_MIN     = 7'd2;
  localparam logic [ENS_W-1:0]          ENS_MAX     = 7'(MAX_ENSEMBLE);
  localparam logic [ENS_W-1:0]          ENS_RESET   = 7'd8;
  localparam logic [DEP_W-1:0]          DEP_MIN     = 9'd1;
  localparam logic [DEP_W-1:0]          DEP_MAX     = 9'(MAX_POINTS);
  localparam logic [DEP_W-1:0]          DEP_RESET   = 9'd64;

  localparam logic [CFG_INDEX_W-1:0] REG_ENSEMBLE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH    = 8'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i_sample;
    logic signed [SAMPLE_W-1:0] q_sample;
  } sample_t;

  typedef struct packed {
    logic signed [7:0]    velocity_code;
    logic [POINT_W-1:0]   point_index;
    logic                 last_point;
  } result_t;

  // control that rides along with each request
  typedef struct packed {
    logic               valid;
    logic [POINT_W-1:0] point;
    logic               last;
  } tag_t;

  typedef struct packed {
    tag_t                     tag;
    logic signed [ACC_W-1:0]  re;
    logic signed [ACC_W-1:0]  im;
  } acc_pair_t;

  typedef struct packed {
    tag_t                       tag;
    logic                       zero;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANGLE_W-1:0]  z;
  } cordic_t;

  // atan(2^-k) in binary angle units, pi = 2^31
  function automatic logic signed [ANGLE_W-1:0] angle_step(input int k);
    logic signed [ANGLE_W-1:0] a;
    case (k)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // one vectoring step, clockwise when y is not negative
  function automatic cordic_t cordic_step(input cordic_t c, input int k);
    cordic_t r;
    logic signed [CORDIC_W-1:0] xv;
    logic signed [CORDIC_W-1:0] yv;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    r  = c;
    xv = c.x;
    yv = c.y;
    xs = xv >>> k;
    ys = yv >>> k;
    if (!yv[CORDIC_W-1]) begin
      r.x = xv + ys;
      r.y = yv - xs;
      r.z = c.z + angle_step(k);
    end else begin
      r.x = xv - ys;
      r.y = yv + xs;
      r.z = c.z - angle_step(k);
    end
    return r;
  endfunction

endpackage

// ===== sv/dlv_cordic.sv =====
// pipelined cordic atan2: half-plane fold followed by vectoring stages
module dlv_cordic
  import dlv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  acc_pair_t src,
  output cordic_t   res
);

  acc_pair_t in_reg;
  cordic_t   stg [CORDIC_STAGES+1];
  cordic_t   nxt [CORDIC_STAGES+1];
  cordic_t   fold;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg.tag.valid <= 1'b0;
    end else if (adv) begin
      in_reg <= src;
    end
  end

  // turn the left half-plane into the right one
  always_comb begin
    logic signed [CORDIC_W-1:0] xw;
    logic signed [CORDIC_W-1:0] yw;
    xw        = CORDIC_W'(in_reg.re);
    yw        = CORDIC_W'(in_reg.im);
    fold.tag  = in_reg.tag;
    fold.zero = (in_reg.re == '0) && (in_reg.im == '0);
    fold.x    = xw;
    fold.y    = yw;
    fold.z    = '0;
    if (xw[CORDIC_W-1]) begin
      if (!yw[CORDIC_W-1]) begin
        fold.x = yw;
        fold.y = -xw;
        fold.z = HALF_PI;
      end else begin
        fold.x = -yw;
        fold.y = xw;
        fold.z = -HALF_PI;
      end
    end
  end

  // each stage runs STEPS_PER_STAGE vectoring iterations
  always_comb begin
    cordic_t c;
    nxt[0] = fold;
    for (int s = 0; s < CORDIC_STAGES; s++) begin
      c = stg[s];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        c = cordic_step(c, s * STEPS_PER_STAGE + j);
      end
      nxt[s+1] = c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= CORDIC_STAGES; s++) begin
        stg[s].tag.valid <= 1'b0;
      end
    end else if (adv) begin
      for (int s = 0; s <= CORDIC_STAGES; s++) begin
        stg[s] <= nxt[s];
      end
    end
  end

  assign res = stg[CORDIC_STAGES];

endmodule

// ===== sv/doppler_lag1_velocity_estimator.sv =====
// top level: lag-one autocorrelation per depth point and velocity code output
//
// samples enter on sample/sample_valid/sample_stall in memory order: one row
// holds a sample for every depth point, ensemble_size rows make a frame.
// a request is taken at a clock edge with valid high and stall low.
// for each sample of the last row one result leaves on result/result_valid,
// carrying the velocity code, the depth point and a last-point flag; other
// rows give no result.
// one request is taken every cycle while result_stall does not freeze the
// pipeline; a sample passes through accumulation, fold, eight cordic stages
// of two iterations each, then magnitude, scale and saturate.
// the per-point sums live in a single-port-write memory read one stage
// ahead of the write, with a one-deep bypass for back-to-back points.
// while result_stall holds a waiting result the whole pipeline freezes and
// sample_stall rises; nothing is dropped or repeated.
// cfg writes (cfg_valid/cfg_ready, ready outside reset) set ensemble_size
// (index 0) or depth_points (index 1) and restart the frame; write only when idle.
// synchronous reset clears the counters and valid bits, holds sample_stall
// high and loads ensemble_size 8 and depth_points 64.
module doppler_lag1_velocity_estimator
  import dlv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic adv;
  logic accept;

  logic [ENS_W-1:0]   ensemble_size;
  logic [DEP_W-1:0]   depth_points;
  logic [ENS_W-1:0]   ens_eff;
  logic [DEP_W-1:0]   dep_eff;
  logic [POINT_W-1:0] point_cnt;
  logic [ROW_W-1:0]   row_cnt;
  logic [POINT_W-1:0] p_cur;
  logic [ROW_W-1:0]   r_cur;
  logic               pt_wrap;
  logic [POINT_W-1:0] point_next;
  logic [ROW_W-1:0]   row_next;

  assign adv          = !result_valid || !result_stall;
  assign sample_stall = rst || !adv;
  assign accept       = sample_valid && !sample_stall;
  assign cfg_ready    = !rst;

  // registers out of range are used clamped
  always_comb begin
    if (ensemble_size < ENS_MIN) ens_eff = ENS_MIN;
    else if (ensemble_size > ENS_MAX) ens_eff = ENS_MAX;
    else ens_eff = ensemble_size;
    if (depth_points < DEP_MIN) dep_eff = DEP_MIN;
    else if (depth_points > DEP_MAX) dep_eff = DEP_MAX;
    else dep_eff = depth_points;
  end

  always_comb begin
    p_cur      = ({1'b0, point_cnt} >= dep_eff) ? '0 : point_cnt;
    r_cur      = ({1'b0, row_cnt} >= ens_eff) ? '0 : row_cnt;
    pt_wrap    = ({1'b0, p_cur} + DEP_W'(1)) >= dep_eff;
    point_next = pt_wrap ? '0 : p_cur + POINT_W'(1);
    row_next   = r_cur;
    if (pt_wrap) begin
      row_next = (({1'b0, r_cur} + ENS_W'(1)) >= ens_eff) ? '0 : r_cur + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ensemble_size <= ENS_RESET;
      depth_points  <= DEP_RESET;
      point_cnt     <= '0;
      row_cnt       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENSEMBLE: begin
          ensemble_size <= cfg_data[ENS_W-1:0];
          point_cnt     <= '0;
          row_cnt       <= '0;
        end
        REG_DEPTH: begin
          depth_points <= cfg_data[DEP_W-1:0];
          point_cnt    <= '0;
          row_cnt      <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      point_cnt <= point_next;
      row_cnt   <= row_next;
    end
  end

  // stage 1: previous sample read and replaced at the same address
  logic signed [SAMPLE_W-1:0] prev_i_mem [MAX_POINTS];
  logic signed [SAMPLE_W-1:0] prev_q_mem [MAX_POINTS];
  logic signed [SAMPLE_W-1:0] prev_i;
  logic signed [SAMPLE_W-1:0] prev_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_i            <= prev_i_mem[p_cur];
      prev_q            <= prev_q_mem[p_cur];
      prev_i_mem[p_cur] <= sample.i_sample;
      prev_q_mem[p_cur] <= sample.q_sample;
    end
  end

  tag_t                       s1_tag;
  logic                       s1_rzero;
  logic                       s1_rlast;
  logic signed [SAMPLE_W-1:0] s1_ci;
  logic signed [SAMPLE_W-1:0] s1_cq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else if (adv) begin
      s1_tag.valid <= sample_valid;
      s1_tag.point <= p_cur;
      s1_tag.last  <= ({1'b0, p_cur} == dep_eff - DEP_W'(1));
      s1_rzero     <= (r_cur == '0);
      s1_rlast     <= ({1'b0, r_cur} == ens_eff - ENS_W'(1));
      s1_ci        <= sample.i_sample;
      s1_cq        <= sample.q_sample;
    end
  end

  // stage 2: products, sum read with bypass from the write in flight
  tag_t                      s2_tag;
  logic                      s2_rzero;
  logic                      s2_rlast;
  logic signed [PROD_SW-1:0] s2_ii;
  logic signed [PROD_SW-1:0] s2_qq;
  logic signed [PROD_SW-1:0] s2_iq;
  logic signed [PROD_SW-1:0] s2_qi;

  logic signed [ACC_W-1:0] sum_re_mem [MAX_POINTS];
  logic signed [ACC_W-1:0] sum_im_mem [MAX_POINTS];
  logic signed [ACC_W-1:0] sum_rd_re;
  logic signed [ACC_W-1:0] sum_rd_im;
  logic signed [ACC_W-1:0] byp_re;
  logic signed [ACC_W-1:0] byp_im;
  logic                    byp;
  logic signed [ACC_W-1:0] new_re;
  logic signed [ACC_W-1:0] new_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag.valid <= 1'b0;
    end else if (adv) begin
      s2_tag   <= s1_tag;
      s2_rzero <= s1_rzero;
      s2_rlast <= s1_rlast;
      s2_ii    <= prev_i * s1_ci;
      s2_qq    <= prev_q * s1_cq;
      s2_iq    <= prev_i * s1_cq;
      s2_qi    <= s1_ci * prev_q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_rd_re <= sum_re_mem[s1_tag.point];
      sum_rd_im <= sum_im_mem[s1_tag.point];
      byp       <= s2_tag.valid && (s2_tag.point == s1_tag.point);
      byp_re    <= new_re;
      byp_im    <= new_im;
      if (s2_tag.valid) begin
        sum_re_mem[s2_tag.point] <= new_re;
        sum_im_mem[s2_tag.point] <= new_im;
      end
    end
  end

  // first row of a frame starts the sums afresh
  always_comb begin
    logic signed [LAG_W-1:0] lag_re;
    logic signed [LAG_W-1:0] lag_im;
    logic signed [ACC_W-1:0] base_re;
    logic signed [ACC_W-1:0] base_im;
    lag_re  = LAG_W'(s2_ii) + LAG_W'(s2_qq);
    lag_im  = LAG_W'(s2_iq) - LAG_W'(s2_qi);
    base_re = byp ? byp_re : sum_rd_re;
    base_im = byp ? byp_im : sum_rd_im;
    if (s2_rzero) begin
      new_re = '0;
      new_im = '0;
    end else begin
      new_re = base_re + ACC_W'(lag_re);
      new_im = base_im + ACC_W'(lag_im);
    end
  end

  acc_pair_t cordic_src;
  cordic_t   cordic_res;

  always_comb begin
    cordic_src           = '0;
    cordic_src.tag       = s2_tag;
    cordic_src.tag.valid = s2_tag.valid && s2_rlast;
    cordic_src.re        = new_re;
    cordic_src.im        = new_im;
  end

  dlv_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .src (cordic_src),
    .res (cordic_res)
  );

  // magnitude, scale to code units, saturate and restore the sign
  tag_t               abs_tag;
  logic               abs_zero;
  logic               abs_neg;
  logic [MAG_W-1:0]   abs_mag;
  tag_t               mul_tag;
  logic               mul_zero;
  logic               mul_neg;
  logic [PROD_W-1:0]  mul_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_tag.valid <= 1'b0;
      mul_tag.valid <= 1'b0;
    end else if (adv) begin
      abs_tag  <= cordic_res.tag;
      abs_zero <= cordic_res.zero;
      abs_neg  <= cordic_res.z[ANGLE_W-1];
      abs_mag  <= cordic_res.z[ANGLE_W-1] ? MAG_W'(-cordic_res.z) : MAG_W'(cordic_res.z);
      mul_tag  <= abs_tag;
      mul_zero <= abs_zero;
      mul_neg  <= abs_neg;
      mul_prod <= PROD_W'(abs_mag) * PROD_W'(SCALE_Q16);
    end
  end

  logic [CODE_W-1:0] code_raw;
  logic [7:0]        code_mag;
  logic signed [7:0] code;

  always_comb begin
    code_raw = mul_prod[PROD_W-1:SCALE_SHIFT];
    code_mag = (code_raw > CODE_MAX) ? CODE_MAX[7:0] : code_raw[7:0];
    if (mul_zero) code = '0;
    else if (mul_neg) code = -code_mag;
    else code = code_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid         <= mul_tag.valid;
      result.velocity_code <= code;
      result.point_index   <= mul_tag.point;
      result.last_point    <= mul_tag.last;
    end
  end

endmodule
